[design/ffba_pkg.sv]
// Package for the first-fit block allocator.
// Holds command codes, sequencer states and shared widths; no dependencies.
`timescale 1ns / 1ps
package ffba_pkg;

	localparam int UNITS_DEF   = 1024;
	localparam int FIELD_W     = 11;
	localparam int VALUE_W     = 16;
	localparam int CMD_W       = 2;
	localparam logic [FIELD_W-1:0] UNITS_IN_USE_RST = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESET = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_GET   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_OWN,
		ST_FREE_END,
		ST_WRITE,
		ST_REPLY
	} state_t;

endpackage

[design/ffba_if.sv]
// Channel interfaces of the first-fit block allocator: request, response, config.
// Depends on ffba_pkg for the payload widths.
`timescale 1ns / 1ps
interface ffba_req_if;
	logic                        valid;
	logic                        ready;
	logic [ffba_pkg::CMD_W-1:0]  command;
	logic [ffba_pkg::VALUE_W-1:0] value;
	modport source (output valid, command, value, input ready);
	modport sink   (input valid, command, value, output ready);
endinterface

interface ffba_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic [ffba_pkg::FIELD_W-1:0] block_first;
	logic [ffba_pkg::FIELD_W-1:0] block_last;
	modport source (output valid, status, block_first, block_last, input ready);
	modport sink   (input valid, status, block_first, block_last, output ready);
endinterface

interface ffba_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ffba_pkg::FIELD_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[design/first_fit_block_allocator_unit.sv]
// Usage notes for the first-fit block allocator.
// Request channel carries a command (reset, allocate, free, get k-th block) and
// a value; each accepted transaction yields exactly one response transaction with
// status, block_first and block_last. The config channel writes units_in_use;
// write it only while idle and follow it with a reset command.
// Allocate and get scan the unit map one unit per clock over the active units;
// allocate then marks the units of the found block in the owner memory. Free
// reads the owner of the given unit, then the block end, and clears each unit
// of the block. A reset command sweeps the owner memory, and a range reject
// goes straight to the reply. The owner memory takes one read and one write per clock.
// One command is in flight at a time; req.ready is high only while idle.
// After arst_n the owner memory is cleared in a pass during which no request
// is taken; config writes are taken at any time.
// A response waits in its output register while rsp.ready is low; the next
// request is still accepted, and its reply is held until the register empties.
// Depends on ffba_pkg, ffba_if, ffba_map and ffba_seq.
`timescale 1ns / 1ps
module first_fit_block_allocator_unit #(
	parameter int UNITS = ffba_pkg::UNITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp,
	ffba_cfg_if.sink   cfg
);

	localparam int AW = $clog2(UNITS + 1);
	localparam int IW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int CW = AW + 1;
	localparam int MW = (CW > ffba_pkg::VALUE_W) ? CW : ffba_pkg::VALUE_W;

	logic [ffba_pkg::FIELD_W-1:0] units_q;
	logic [AW-1:0]                n_units;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= ffba_pkg::UNITS_IN_USE_RST;
		end else if (cfg.valid) begin
			units_q <= cfg.data;
		end
	end

	assign n_units = (MW'(units_q) > MW'(UNITS)) ? AW'(UNITS) : AW'(units_q);

	logic          own_we, own_re, end_we;
	logic [IW-1:0] own_wa, own_ra, end_wa, end_ra;
	logic [AW-1:0] own_wd, own_rd, end_wd, end_rd;

	ffba_seq #(.UNITS(UNITS), .AW(AW), .IW(IW), .CW(CW), .MW(MW)) u_seq (
		.clk(clk), .arst_n(arst_n), .n_units(n_units), .req(req), .rsp(rsp),
		.own_we(own_we), .own_wa(own_wa), .own_wd(own_wd),
		.own_re(own_re), .own_ra(own_ra), .own_rd(own_rd),
		.end_we(end_we), .end_wa(end_wa), .end_wd(end_wd),
		.end_ra(end_ra), .end_rd(end_rd)
	);

	ffba_map #(.UNITS(UNITS), .AW(AW), .IW(IW)) u_map (
		.clk(clk),
		.own_we(own_we), .own_wa(own_wa), .own_wd(own_wd),
		.own_re(own_re), .own_ra(own_ra), .own_rd(own_rd),
		.end_we(end_we), .end_wa(end_wa), .end_wd(end_wd),
		.end_ra(end_ra), .end_rd(end_rd)
	);

endmodule

[design/ffba_map.sv]
// Unit map storage: the owner memory (start unit per unit) and the block end memory.
// One write and one registered read port on each; depends on nothing else.
`timescale 1ns / 1ps
module ffba_map #(
	parameter int UNITS = 1024,
	parameter int AW    = 11,
	parameter int IW    = 10
) (
	input  logic          clk,
	input  logic          own_we,
	input  logic [IW-1:0] own_wa,
	input  logic [AW-1:0] own_wd,
	input  logic          own_re,
	input  logic [IW-1:0] own_ra,
	output logic [AW-1:0] own_rd,
	input  logic          end_we,
	input  logic [IW-1:0] end_wa,
	input  logic [AW-1:0] end_wd,
	input  logic [IW-1:0] end_ra,
	output logic [AW-1:0] end_rd
);

	logic [AW-1:0] own_mem [UNITS];
	logic [AW-1:0] end_mem [UNITS];

	always_ff @(posedge clk) begin
		if (own_we) begin
			own_mem[own_wa] <= own_wd;
		end
		if (own_re) begin
			own_rd <= own_mem[own_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (end_we) begin
			end_mem[end_wa] <= end_wd;
		end
		end_rd <= end_mem[end_ra];
	end

endmodule

[design/ffba_seq.sv]
// Command sequencer with the shared scan/compare unit and the response register.
// Depends on ffba_pkg and ffba_if; drives the map memories of ffba_map through its ports.
`timescale 1ns / 1ps
module ffba_seq #(
	parameter int UNITS = 1024,
	parameter int AW    = 11,
	parameter int IW    = 10,
	parameter int CW    = 12,
	parameter int MW    = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [AW-1:0]  n_units,
	ffba_req_if.sink       req,
	ffba_rsp_if.source     rsp,
	output logic           own_we,
	output logic [IW-1:0]  own_wa,
	output logic [AW-1:0]  own_wd,
	output logic           own_re,
	output logic [IW-1:0]  own_ra,
	input  logic [AW-1:0]  own_rd,
	output logic           end_we,
	output logic [IW-1:0]  end_wa,
	output logic [AW-1:0]  end_wd,
	output logic [IW-1:0]  end_ra,
	input  logic [AW-1:0]  end_rd
);

	ffba_pkg::state_t state_q, state_d;

	ffba_pkg::cmd_t cmd_q;
	logic [ffba_pkg::VALUE_W-1:0] val_q;
	logic [AW-1:0] count_q;
	logic [CW-1:0] rd_u_q;
	logic [AW-1:0] chk_u_s1;
	logic          valid_s1;
	logic [AW-1:0] run_q;
	logic [AW-1:0] seen_q;
	logic [IW-1:0] clr_q;
	logic          clr_rsp_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] wr_last_q;
	logic [AW-1:0] wr_val_q;
	logic          st_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] last_q;
	logic          rsp_valid_q;

	logic          accept;
	logic          val_bad;
	logic          issue;
	logic [AW-1:0] run_nx;
	logic [AW-1:0] seen_nx;
	logic          own_match;
	logic          hit;
	logic          miss;
	logic          clr_done;
	logic          wr_done;
	logic          rsp_load;

	assign accept   = (state_q == ffba_pkg::ST_IDLE) && req.valid;
	assign req.ready = (state_q == ffba_pkg::ST_IDLE);

	// Range check of the incoming value: zero or above the active unit or block count.
	always_comb begin
		val_bad = 1'b0;
		unique case (ffba_pkg::cmd_t'(req.command))
			ffba_pkg::CMD_ALLOC, ffba_pkg::CMD_FREE: begin
				val_bad = (req.value == '0) || (MW'(req.value) > MW'(n_units));
			end
			ffba_pkg::CMD_GET: begin
				val_bad = (req.value == '0) || (MW'(req.value) > MW'(count_q));
			end
			default: begin
				val_bad = 1'b0;
			end
		endcase
	end

	// Shared scan unit: one unit of the map is read per cycle and judged from the registered read data.
	assign issue     = (state_q == ffba_pkg::ST_SCAN) && (MW'(rd_u_q) <= MW'(n_units));
	assign run_nx    = (own_rd == '0) ? run_q + AW'(1) : '0;
	assign own_match = (own_rd == chk_u_s1);
	assign seen_nx   = seen_q + AW'(own_match);
	assign hit = (state_q == ffba_pkg::ST_SCAN) && valid_s1 &&
		((cmd_q == ffba_pkg::CMD_ALLOC) ? (run_nx == AW'(val_q))
		                                : (own_match && seen_nx == AW'(val_q)));
	assign miss     = (state_q == ffba_pkg::ST_SCAN) && !valid_s1 && !issue;
	assign clr_done = (clr_q == IW'(UNITS - 1));
	assign wr_done  = (wr_ptr_q == wr_last_q);
	assign rsp_load = (state_q == ffba_pkg::ST_REPLY) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::ST_CLEAR: begin
				if (clr_done) begin
					state_d = clr_rsp_q ? ffba_pkg::ST_REPLY : ffba_pkg::ST_IDLE;
				end
			end
			ffba_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (ffba_pkg::cmd_t'(req.command))
						ffba_pkg::CMD_RESET: state_d = ffba_pkg::ST_CLEAR;
						ffba_pkg::CMD_FREE: begin
							state_d = val_bad ? ffba_pkg::ST_REPLY : ffba_pkg::ST_FREE_RD;
						end
						default: begin
							state_d = val_bad ? ffba_pkg::ST_REPLY : ffba_pkg::ST_SCAN;
						end
					endcase
				end
			end
			ffba_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = (cmd_q == ffba_pkg::CMD_ALLOC) ? ffba_pkg::ST_WRITE
					                                         : ffba_pkg::ST_REPLY;
				end else if (miss) begin
					state_d = ffba_pkg::ST_REPLY;
				end
			end
			ffba_pkg::ST_FREE_RD:  state_d = ffba_pkg::ST_FREE_OWN;
			ffba_pkg::ST_FREE_OWN: begin
				state_d = (own_rd == '0) ? ffba_pkg::ST_REPLY : ffba_pkg::ST_FREE_END;
			end
			ffba_pkg::ST_FREE_END: state_d = ffba_pkg::ST_WRITE;
			ffba_pkg::ST_WRITE: begin
				if (wr_done) begin
					state_d = ffba_pkg::ST_REPLY;
				end
			end
			ffba_pkg::ST_REPLY: begin
				if (rsp_load) begin
					state_d = ffba_pkg::ST_IDLE;
				end
			end
			default: state_d = ffba_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Memory port steering.
	always_comb begin
		own_re = 1'b0;
		own_ra = IW'(rd_u_q - CW'(1));
		if (state_q == ffba_pkg::ST_SCAN) begin
			own_re = issue;
		end else if (state_q == ffba_pkg::ST_FREE_RD) begin
			own_re = 1'b1;
			own_ra = IW'(val_q - ffba_pkg::VALUE_W'(1));
		end
		own_we = (state_q == ffba_pkg::ST_CLEAR) || (state_q == ffba_pkg::ST_WRITE);
		own_wa = (state_q == ffba_pkg::ST_CLEAR) ? clr_q : IW'(wr_ptr_q - AW'(1));
		own_wd = (state_q == ffba_pkg::ST_CLEAR) ? '0 : wr_val_q;
		end_we = hit && (cmd_q == ffba_pkg::CMD_ALLOC);
		end_wa = IW'(chk_u_s1 - AW'(val_q));
		end_wd = chk_u_s1;
		end_ra = IW'(own_rd - AW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (state_q == ffba_pkg::ST_CLEAR) begin
				clr_q <= clr_done ? '0 : clr_q + IW'(1);
				if (clr_done) begin
					count_q <= '0;
				end
			end
			if (accept) begin
				clr_rsp_q <= (ffba_pkg::cmd_t'(req.command) == ffba_pkg::CMD_RESET);
			end
			if (state_q == ffba_pkg::ST_WRITE && wr_done) begin
				if (cmd_q == ffba_pkg::CMD_ALLOC) begin
					count_q <= count_q + AW'(1);
				end else if (count_q != '0) begin
					count_q <= count_q - AW'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current command and the reply fields.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_u_q <= rd_u_q + CW'(1);
		end
		chk_u_s1 <= AW'(rd_u_q);
		if (state_q == ffba_pkg::ST_SCAN && valid_s1) begin
			run_q  <= run_nx;
			seen_q <= seen_nx;
		end
		unique case (state_q)
			ffba_pkg::ST_IDLE: begin
				cmd_q   <= ffba_pkg::cmd_t'(req.command);
				val_q   <= req.value;
				rd_u_q  <= CW'(1);
				run_q   <= '0;
				seen_q  <= '0;
				st_q    <= val_bad;
				first_q <= '0;
				last_q  <= '0;
			end
			ffba_pkg::ST_CLEAR: begin
				st_q    <= 1'b0;
				first_q <= '0;
				last_q  <= '0;
			end
			ffba_pkg::ST_SCAN: begin
				if (hit) begin
					first_q   <= (cmd_q == ffba_pkg::CMD_ALLOC)
						? chk_u_s1 - AW'(val_q) + AW'(1) : chk_u_s1;
					wr_ptr_q  <= chk_u_s1 - AW'(val_q) + AW'(1);
					wr_last_q <= chk_u_s1;
					wr_val_q  <= chk_u_s1 - AW'(val_q) + AW'(1);
				end else if (miss) begin
					st_q <= 1'b1;
				end
			end
			ffba_pkg::ST_FREE_OWN: begin
				first_q <= own_rd;
				st_q    <= (own_rd == '0);
			end
			ffba_pkg::ST_FREE_END: begin
				// A live block always covers first..last, so the whole range is released.
				last_q    <= end_rd;
				wr_ptr_q  <= first_q;
				wr_last_q <= end_rd;
				wr_val_q  <= '0;
			end
			ffba_pkg::ST_WRITE: begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	logic                         rsp_st_q;
	logic [ffba_pkg::FIELD_W-1:0] rsp_first_q;
	logic [ffba_pkg::FIELD_W-1:0] rsp_last_q;

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_st_q    <= st_q;
			rsp_first_q <= ffba_pkg::FIELD_W'(first_q);
			rsp_last_q  <= ffba_pkg::FIELD_W'(last_q);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_st_q;
	assign rsp.block_first = rsp_first_q;
	assign rsp.block_last  = rsp_last_q;

endmodule

[design/ffba_checker.sv]
// Port-level checks for the first-fit block allocator, attached with bind.
// Depends on ffba_pkg for the field widths.
`timescale 1ns / 1ps
module ffba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_status,
	input logic [ffba_pkg::FIELD_W-1:0] rsp_first,
	input logic [ffba_pkg::FIELD_W-1:0] rsp_last
);

	// A stalled response stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// One command at a time: the request side closes right after a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while a command is in progress");

	// A rejected command reports no units.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_first == '0 && rsp_last == '0)
		else $error("rejected response carries unit numbers");

	// A freed block is reported as a nonempty ordered range.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_last != '0 |-> !rsp_status && rsp_first != '0 &&
			rsp_first <= rsp_last)
		else $error("freed block range is malformed");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.status), .rsp_first(rsp.block_first), .rsp_last(rsp.block_last)
);
